// ===== hw/rtl/srd_pkg.sv =====
// shared types and constants for the switch remap debouncer
// no dependencies

package srd_pkg;

  localparam int unsigned NUM_SP   = 8;
  localparam int unsigned NUM_SG   = 14;
  localparam int unsigned NUM_SRC  = NUM_SP + NUM_SG;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned IDS_PER_REG = 7;
  localparam int unsigned ASSIGN_W = ID_W * IDS_PER_REG;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IGNITION    = 3'd0;
  localparam cfg_idx_t CFG_SP_ASSIGN   = 3'd1;
  localparam cfg_idx_t CFG_SG_ASSIGN_L = 3'd2;
  localparam cfg_idx_t CFG_SG_ASSIGN_H = 3'd3;
  localparam cfg_idx_t CFG_DEB_CYCLES  = 3'd4;

  localparam logic [ID_W-1:0]     IGNITION_RST = '0;
  localparam logic [ASSIGN_W-1:0] ASSIGN_RST   = '1;
  localparam logic [CNT_W-1:0]    CYCLES_RST   = 7'd5;

endpackage

// ===== hw/rtl/srd_in_if.sv =====
// input channel: one scan tick of raw sp and sg bits
// depends on srd_pkg

interface srd_in_if;
  logic                          valid;
  logic                          ready;
  logic [srd_pkg::NUM_SP-1:0]    sp_raw;
  logic [srd_pkg::NUM_SG-1:0]    sg_raw;

  modport source (output valid, output sp_raw, output sg_raw, input ready);
  modport sink   (input valid, input sp_raw, input sg_raw, output ready);
endinterface

// ===== hw/rtl/srd_out_if.sv =====
// output channel: debounced states and changed flags
// depends on srd_pkg

interface srd_out_if;
  logic                        valid;
  logic                        ready;
  logic [srd_pkg::OUT_W-1:0]   switch_states;
  logic [srd_pkg::OUT_W-1:0]   changed_flags;
  logic                        any_changed;

  modport source (output valid, output switch_states, output changed_flags,
                  output any_changed, input ready);
  modport sink   (input valid, input switch_states, input changed_flags,
                  input any_changed, output ready);
endinterface

// ===== hw/rtl/switch_remap_debouncer_core.sv =====
// switch remap debouncer: input register, remap and debounce, result register
// depends on srd_pkg, srd_in_if, srd_out_if
// an accepted item goes through the input register and then the result register before its result is offered
// throughput: one item per cycle while the output is not stalled, set by the single remap/debounce stage
// reset clears configuration to defaults and all states and counts to zero

module switch_remap_debouncer_core #(
  parameter int unsigned NUM_SWITCHES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  srd_in_if.sink                            in_i,
  srd_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  srd_pkg::cfg_idx_t                 cfg_idx_i,
  input  logic [srd_pkg::ASSIGN_W-1:0]      cfg_wdata_i
);

  localparam int unsigned IdW  = srd_pkg::ID_W;
  localparam int unsigned CntW = srd_pkg::CNT_W;
  localparam int unsigned NSrc = srd_pkg::NUM_SRC;
  localparam int unsigned NIds = srd_pkg::IDS_PER_REG;

  // configuration
  logic [IdW-1:0]               ign_q;
  logic [srd_pkg::ASSIGN_W-1:0] sp_asg_q, sgl_asg_q, sgh_asg_q;
  logic [CntW-1:0]              cycles_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_q     <= srd_pkg::IGNITION_RST;
      sp_asg_q  <= srd_pkg::ASSIGN_RST;
      sgl_asg_q <= srd_pkg::ASSIGN_RST;
      sgh_asg_q <= srd_pkg::ASSIGN_RST;
      cycles_q  <= srd_pkg::CYCLES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srd_pkg::CFG_IGNITION:    ign_q     <= cfg_wdata_i[IdW-1:0];
        srd_pkg::CFG_SP_ASSIGN:   sp_asg_q  <= cfg_wdata_i;
        srd_pkg::CFG_SG_ASSIGN_L: sgl_asg_q <= cfg_wdata_i;
        srd_pkg::CFG_SG_ASSIGN_H: sgh_asg_q <= cfg_wdata_i;
        srd_pkg::CFG_DEB_CYCLES:  cycles_q  <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, out_valid_q;
  logic s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  // input register
  logic [srd_pkg::NUM_SP-1:0] sp_q;
  logic [srd_pkg::NUM_SG-1:0] sg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sp_q <= in_i.sp_raw;
      sg_q <= in_i.sg_raw;
    end
  end

  // remap sources onto logical switches
  logic [IdW-1:0]          src_id [NSrc];
  logic [NSrc-1:0]         src_bit;
  logic [NUM_SWITCHES-1:0] raw;

  assign src_bit = {sg_q, sp_q};

  always_comb begin
    src_id[0] = ign_q;
    for (int k = 0; k < NIds; k++) begin
      src_id[1 + k]            = sp_asg_q[IdW*k +: IdW];
      src_id[1 + NIds + k]     = sgl_asg_q[IdW*k +: IdW];
      src_id[1 + 2*NIds + k]   = sgh_asg_q[IdW*k +: IdW];
    end
  end

  always_comb begin
    raw = '0;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      for (int k = 0; k < NSrc; k++) begin
        if (src_bit[k] && (src_id[k] == IdW'(i))) begin
          raw[i] = 1'b1;
        end
      end
    end
  end

  // countdown debounce
  logic [NUM_SWITCHES-1:0] state_q, state_d;
  logic [CntW-1:0]         cnt_q [NUM_SWITCHES];
  logic [CntW-1:0]         cnt_d [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] flag_d;

  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      state_d[i] = state_q[i];
      if (state_q[i] == raw[i]) begin
        cnt_d[i] = '0;
      end else if (cnt_q[i] == '0) begin
        cnt_d[i] = cycles_q;
      end else begin
        cnt_d[i] = cnt_q[i] - CntW'(1);
        if (cnt_d[i] == CntW'(1)) begin
          state_d[i] = raw[i];
        end
      end
      flag_d[i] = (cnt_d[i] == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (s1_adv) begin
      state_q <= state_d;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // visible bits of the result
  logic [srd_pkg::OUT_W-1:0] states_vis, flags_vis;

  for (genvar j = 0; j < srd_pkg::OUT_W; j++) begin : g_vis
    if (j < NUM_SWITCHES) begin : g_on
      assign states_vis[j] = state_d[j];
      assign flags_vis[j]  = flag_d[j];
    end else begin : g_off
      assign states_vis[j] = 1'b0;
      assign flags_vis[j]  = 1'b0;
    end
  end

  // result register
  logic [srd_pkg::OUT_W-1:0] states_q, flags_q;
  logic                      any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      states_q <= states_vis;
      flags_q  <= flags_vis;
      any_q    <= |flag_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.switch_states = states_q;
  assign out_o.changed_flags = flags_q;
  assign out_o.any_changed   = any_q;

  // checks
  a_any_covers_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (|flags_q)) |-> any_q)
    else $error("any_changed low with a changed flag set");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(state_q))
    else $error("switch state moved without an item");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== test/switch_remap_debouncer_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for switch_remap_debouncer_core: remaps raw sp/sg scans,
// predicts the debounced states and changed flags per scan and checks every result
// depends on srd_pkg, srd_in_if, srd_out_if and the core itself

module switch_remap_debouncer_core_test;
  import srd_pkg::*;

  localparam int unsigned SWITCHES    = 32;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam cfg_idx_t CFG_FIRST_UNUSED = CFG_DEB_CYCLES + 3'd1;
  localparam cfg_idx_t CFG_LAST_UNUSED  = '1;

  typedef struct packed {
    logic [OUT_W-1:0] states;
    logic [OUT_W-1:0] flags;
    logic             any_chg;
  } scan_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_t            cfg_idx_i;
  logic [ASSIGN_W-1:0] cfg_wdata_i;

  srd_in_if  scan_if ();
  srd_out_if state_if ();

  switch_remap_debouncer_core #(
    .NUM_SWITCHES(SWITCHES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (scan_if),
    .out_o      (state_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor copy of configuration and switch state
  logic [ID_W-1:0]     ign_id;
  logic [ASSIGN_W-1:0] sp_ids;
  logic [ASSIGN_W-1:0] sg_lo_ids;
  logic [ASSIGN_W-1:0] sg_hi_ids;
  logic [CNT_W-1:0]    load_cycles;
  logic [SWITCHES-1:0] stable_bits;
  logic [CNT_W-1:0]    counts [SWITCHES];

  scan_result_t pending_results [$];
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  rx_hold;
  bit           idle_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void reset_model();
    ign_id      = IGNITION_RST;
    sp_ids      = ASSIGN_RST;
    sg_lo_ids   = ASSIGN_RST;
    sg_hi_ids   = ASSIGN_RST;
    load_cycles = CYCLES_RST;
    stable_bits = '0;
    for (int i = 0; i < SWITCHES; i++) counts[i] = '0;
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [ASSIGN_W-1:0] data);
    case (idx)
      CFG_IGNITION:    ign_id = data[ID_W-1:0];
      CFG_SP_ASSIGN:   sp_ids = data;
      CFG_SG_ASSIGN_L: sg_lo_ids = data;
      CFG_SG_ASSIGN_H: sg_hi_ids = data;
      CFG_DEB_CYCLES:  load_cycles = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // remap one scan onto the logical switches and step every countdown
  function automatic scan_result_t debounce_scan(input logic [NUM_SP-1:0] sp,
                                                 input logic [NUM_SG-1:0] sg);
    logic [SWITCHES-1:0] hits;
    logic [ID_W-1:0]     id;
    scan_result_t        res;
    hits = '0;
    for (int k = 0; k < NUM_SP; k++) begin
      if (sp[k]) begin
        if (k == 0) id = ign_id;
        else id = sp_ids[ID_W*(k-1) +: ID_W];
        if (id < SWITCHES) hits[id] = 1'b1;
      end
    end
    for (int k = 0; k < NUM_SG; k++) begin
      if (sg[k]) begin
        if (k < IDS_PER_REG) id = sg_lo_ids[ID_W*k +: ID_W];
        else id = sg_hi_ids[ID_W*(k-IDS_PER_REG) +: ID_W];
        if (id < SWITCHES) hits[id] = 1'b1;
      end
    end
    res = '0;
    for (int i = 0; i < SWITCHES; i++) begin
      if (stable_bits[i] == hits[i]) begin
        counts[i] = '0;
      end else if (counts[i] == '0) begin
        counts[i] = load_cycles;
      end else begin
        counts[i] = counts[i] - 1'b1;
        if (counts[i] == 1) stable_bits[i] = hits[i];
      end
      res.flags[i] = (counts[i] == 1);
    end
    res.states  = stable_bits;
    res.any_chg = |res.flags;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && state_if.valid && state_if.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected item: expected none actual states %h flags %h",
                 $time, state_if.switch_states, state_if.changed_flags);
      end else begin
        want = pending_results.pop_front();
        check_field("switch_states", want.states, state_if.switch_states);
        check_field("changed_flags", want.flags, state_if.changed_flags);
        check_field("any_changed", OUT_W'(want.any_chg), OUT_W'(state_if.any_changed));
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    state_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        rx_hold--;
        state_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        state_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        state_if.ready <= 1'b0;
      end else begin
        state_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_scan(input logic [NUM_SP-1:0] sp, input logic [NUM_SG-1:0] sg);
    scan_if.valid  <= 1'b1;
    scan_if.sp_raw <= sp;
    scan_if.sg_raw <= sg;
    do @(posedge clk_i); while (!scan_if.ready);
    pending_results.push_back(debounce_scan(sp, sg));
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      scan_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    scan_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ASSIGN_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [ASSIGN_W-1:0] rand_word();
    return ASSIGN_W'({$urandom, $urandom});
  endfunction

  // mostly valid ids, some out of range, some crowded onto a few switches
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return ID_W'($urandom_range(SWITCHES, (1 << ID_W) - 1));
      1:       return ID_W'($urandom_range(0, 3));
      default: return ID_W'($urandom_range(0, SWITCHES - 1));
    endcase
  endfunction

  function automatic logic [ASSIGN_W-1:0] random_ids();
    logic [ASSIGN_W-1:0] ids;
    for (int k = 0; k < IDS_PER_REG; k++) ids[ID_W*k +: ID_W] = pick_id();
    return ids;
  endfunction

  task automatic configure(input logic [CNT_W-1:0] load);
    logic [ASSIGN_W-1:0] data;
    wait_drained();
    data = rand_word();
    data[ID_W-1:0] = pick_id();
    write_reg(CFG_IGNITION, data);
    write_reg(CFG_SP_ASSIGN, random_ids());
    write_reg(CFG_SG_ASSIGN_L, random_ids());
    write_reg(CFG_SG_ASSIGN_H, random_ids());
    data = rand_word();
    data[CNT_W-1:0] = load;
    write_reg(CFG_DEB_CYCLES, data);
    if ($urandom_range(0, 1) == 0)
      write_reg(cfg_idx_t'(CFG_FIRST_UNUSED + $urandom_range(0, 2)), rand_word());
  endtask

  // runs of a held pattern long enough to settle, with glitches and short bursts
  task automatic run_scans(input int unsigned count);
    logic [NUM_SP-1:0] sp;
    logic [NUM_SG-1:0] sg;
    int unsigned       hold;
    int unsigned       sent;
    sent = 0;
    while (sent < count) begin
      sp = NUM_SP'($urandom);
      sg = NUM_SG'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        sp &= NUM_SP'($urandom);
        sg &= NUM_SG'($urandom);
      end
      if (load_cycles > 16 && $urandom_range(0, 3) != 0)
        hold = $urandom_range(load_cycles, load_cycles + 10);
      else
        hold = $urandom_range(1, (load_cycles > 16) ? 8 : load_cycles + 4);
      for (int unsigned t = 0; t < hold && sent < count; t++) begin
        if (load_cycles <= 16 && $urandom_range(0, 9) == 0)
          send_scan(sp ^ NUM_SP'($urandom), sg ^ NUM_SG'($urandom));
        else
          send_scan(sp, sg);
        sender_gap();
        sent++;
      end
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
  endtask

  // defaults: only sp0 reaches switch 0, every other id is out of range
  task automatic test_reset_defaults();
    repeat (5) begin
      send_scan(8'h01, '0);
      sender_gap();
    end
    send_scan('1, '1);
    repeat (5) begin
      send_scan('0, '0);
      sender_gap();
    end
  endtask

  // edge ids, out of range ids, merged hits, shortest legal countdown
  task automatic test_remap_and_merge();
    wait_drained();
    write_reg(CFG_IGNITION, {{(ASSIGN_W-ID_W){1'b1}}, ID_W'(SWITCHES - 1)});
    write_reg(CFG_SP_ASSIGN, {8'd255, 8'd32, 8'd31, 8'd3, 8'd2, 8'd1, 8'd0});
    write_reg(CFG_SG_ASSIGN_L, {8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4});
    write_reg(CFG_SG_ASSIGN_H, {8'd31, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12, 8'd11});
    write_reg(CFG_DEB_CYCLES, {{(ASSIGN_W-CNT_W){1'b1}}, 7'd2});
    write_reg(CFG_FIRST_UNUSED, '0);
    write_reg(CFG_LAST_UNUSED, '0);
    repeat (3) send_scan('1, '1);
    repeat (2) send_scan(8'h01, '0);
    repeat (2) send_scan('0, '0);
  endtask

  // countdown loads of zero and one never move the stable state
  task automatic test_short_loads();
    wait_drained();
    write_reg(CFG_DEB_CYCLES, {{(ASSIGN_W-CNT_W){1'b1}}, 7'd0});
    repeat (3) send_scan('1, '1);
    wait_drained();
    write_reg(CFG_DEB_CYCLES, {{(ASSIGN_W-CNT_W){1'b0}}, 7'd1});
    repeat (3) send_scan('1, '1);
  endtask

  task automatic test_backpressure();
    logic [NUM_SP-1:0] sp;
    logic [NUM_SG-1:0] sg;
    configure(7'd3);
    rx_hold = 150;
    for (int k = 0; k < 40; k++) begin
      if (k % 6 == 0) begin
        sp = NUM_SP'($urandom);
        sg = NUM_SG'($urandom);
      end
      send_scan(sp, sg);
    end
    wait_drained();
    repeat (10) begin
      send_scan(~sp, ~sg);
      sender_gap();
    end
  endtask

  task automatic test_random_scans();
    logic [CNT_W-1:0] loads [8];
    loads = '{7'd2, 7'd3, 7'd5, 7'd0, 7'd127, 7'd1, 7'd4, 7'd2};
    loads[6] = CNT_W'($urandom_range(4, 20));
    foreach (loads[p]) begin
      configure(loads[p]);
      run_scans((loads[p] == 7'd127) ? 260 : 120);
    end
  endtask

  task automatic test_steady_stream();
    configure(CNT_W'($urandom_range(2, 8)));
    idle_on = 1'b0;
    run_scans(130);
  endtask

  initial begin
    errors  = 0;
    cycles  = 0;
    rx_hold = 0;
    idle_on = 1'b1;
    reset_model();
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_IGNITION;
    cfg_wdata_i    <= '0;
    scan_if.valid  <= 1'b0;
    scan_if.sp_raw <= '0;
    scan_if.sg_raw <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_remap_and_merge();
    test_short_loads();
    test_backpressure();
    test_random_scans();
    test_steady_stream();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/srd_pkg.sv
hw/rtl/srd_in_if.sv
hw/rtl/srd_out_if.sv
hw/rtl/switch_remap_debouncer_core.sv
test/switch_remap_debouncer_core_test.sv
